>>> hdl/lctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lctd_pkg - shared types and constants for the load-cell touch detector
// Beat payload types, register map, reset values and the queue geometry.
// ----------------------------------------------------------------------------
package lctd_pkg;

  // Register map: byte address is 4 * index
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_PROBE_ENABLE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_JUMP_LIMIT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_CONFIDENCE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_AVERAGE_WEIGHT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOUCH_THRESHOLD = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS_BAND = 3'd5;

  // Reset values
  localparam logic        RST_PROBE_ENABLE    = 1'b1;
  localparam logic [30:0] RST_JUMP_LIMIT      = 31'd196608;
  localparam logic [3:0]  RST_MAX_CONFIDENCE  = 4'd5;
  localparam logic [16:0] RST_AVERAGE_WEIGHT  = 17'd131;
  localparam logic [31:0] RST_TOUCH_THRESHOLD = 32'd196608;
  localparam logic [30:0] RST_HYSTERESIS_BAND = 31'd13107;

  // Q1.16 unity weight
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Input action codes
  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_TARE   = 1'b1;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               action;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic               touch;
    logic signed [31:0] force_difference;
    logic signed [31:0] used_sample;
    logic               spike_replaced;
  } out_item_t;

  typedef struct packed {
    logic               probe_enable;
    logic [30:0]        jump_limit;
    logic [3:0]         max_confidence;
    logic [16:0]        average_weight;
    logic signed [31:0] touch_threshold;
    logic [30:0]        hysteresis_band;
  } cfg_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic               tare;
    logic signed [31:0] used_sample;
    logic               spike_replaced;
  } cmd_t;

endpackage

>>> hdl/lctd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lctd_front - input beat acceptance and spike rejection
// Drops samples while the probe is off, runs the confidence-count spike
// filter and pushes tare / sample commands into the queue.
// ----------------------------------------------------------------------------
module lctd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lctd_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lctd_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output lctd_pkg::cmd_t    q_data_o
);
  import lctd_pkg::*;

  logic signed [31:0] prev_q, prev_d;
  logic [3:0]         conf_q, conf_d;

  logic               accept;
  logic               is_tare;
  logic signed [32:0] jump;
  logic [32:0]        jump_abs;
  logic               is_spike;
  logic [3:0]         conf_dec;
  logic [4:0]         conf_inc;
  logic               replace;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_tare    = (in_data_i.action == ACTION_TARE);
  assign q_push_o   = accept && (is_tare || cfg_i.probe_enable);

  always_comb begin
    jump     = {in_data_i.sample_value[31], in_data_i.sample_value} - {prev_q[31], prev_q};
    jump_abs = jump[32] ? 33'(-jump) : 33'(jump);
    is_spike = jump_abs > {2'b00, cfg_i.jump_limit};
    conf_dec = (conf_q == 4'd0) ? 4'd0 : conf_q - 4'd1;
    conf_inc = {1'b0, conf_q} + 5'd1;
    replace  = 1'b0;
    prev_d   = prev_q;
    if (is_spike) begin
      conf_d = conf_dec;
      // count still positive: hold on to the last good sample
      if (conf_dec != 4'd0) begin
        replace = 1'b1;
      end else begin
        prev_d = in_data_i.sample_value;
      end
    end else begin
      prev_d = in_data_i.sample_value;
      conf_d = (conf_inc > {1'b0, cfg_i.max_confidence}) ? cfg_i.max_confidence
                                                         : conf_inc[3:0];
    end
  end

  always_comb begin
    q_data_o.tare           = is_tare;
    q_data_o.used_sample    = replace ? prev_q : in_data_i.sample_value;
    q_data_o.spike_replaced = replace;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      conf_q <= '0;
    end else if (q_push_o && !is_tare) begin
      prev_q <= prev_d;
      conf_q <= conf_d;
    end
  end

  // a replaced sample always leaves a positive count behind
  a_replace_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && !is_tare && replace |=> conf_q != 4'd0)
    else $error("spike replaced with zero confidence count");

endmodule

>>> hdl/lctd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lctd_queue - short command queue between front and back
// Flop-based FIFO so each side can stall on its own.
// ----------------------------------------------------------------------------
module lctd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lctd_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output lctd_pkg::cmd_t pop_data_o,
  output logic           valid_o
);
  import lctd_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  assign full_o     = (count_q == CNT_FULL);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("queue pop while empty");

endmodule

>>> hdl/lctd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lctd_back - running average, force difference and touch hysteresis
// Stage one folds the sample into the average, stage two forms the
// saturated difference and the touch decision in the output register.
// ----------------------------------------------------------------------------
module lctd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lctd_pkg::cfg_t     cfg_i,
  input  logic               q_valid_i,
  input  lctd_pkg::cmd_t     q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lctd_pkg::out_item_t out_data_o
);
  import lctd_pkg::*;

  logic               advance;

  logic signed [47:0] avg_q, avg_d;
  logic               seed_q;
  logic               s1_valid_q;
  logic signed [31:0] s1_used_q;
  logic               s1_replaced_q;
  logic               out_valid_q;
  out_item_t          out_q, out_d;
  logic               touch_q;

  // stage one
  logic [16:0]        w_eff;
  logic signed [47:0] s_shift;
  logic signed [48:0] delta;
  logic signed [32:0] delta_hi;
  logic [15:0]        delta_lo;
  logic signed [50:0] prod_hi;
  logic [32:0]        prod_lo;
  logic [33:0]        lo_round;
  logic signed [50:0] avg_sum;

  // stage two
  logic signed [47:0] s1_shift;
  logic signed [48:0] diff_full;
  logic signed [49:0] diff_rnd;
  logic signed [33:0] diff_w;
  logic signed [31:0] diff_sat;
  logic signed [32:0] diff_ext;
  logic signed [32:0] upper, lower;
  logic               touch_d;

  assign advance = !(out_valid_q && out_stall_i);
  assign q_pop_o = q_valid_i && advance;

  // avg + round(((S << 16) - avg) * w / 2^16); the product is split at bit 16
  always_comb begin
    if (seed_q) begin
      w_eff = ONE_Q16;
    end else begin
      w_eff = (cfg_i.average_weight > ONE_Q16) ? ONE_Q16 : cfg_i.average_weight;
    end
    s_shift  = {q_data_i.used_sample, 16'h0000};
    delta    = {s_shift[47], s_shift} - {avg_q[47], avg_q};
    delta_hi = delta[48:16];
    delta_lo = delta[15:0];
    prod_hi  = 51'(delta_hi) * 51'($signed({1'b0, w_eff}));
    prod_lo  = 33'(delta_lo) * 33'(w_eff);
    lo_round = {1'b0, prod_lo} + 34'd32768;
    avg_sum  = {{3{avg_q[47]}}, avg_q} + prod_hi + $signed({33'd0, lo_round[33:16]});
    avg_d    = avg_sum[47:0];
  end

  always_comb begin
    s1_shift  = {s1_used_q, 16'h0000};
    diff_full = {avg_q[47], avg_q} - {s1_shift[47], s1_shift};
    diff_rnd  = {diff_full[48], diff_full} + 50'sd32768;
    diff_w    = diff_rnd[49:16];
    if (diff_w[33:31] == 3'b000 || diff_w[33:31] == 3'b111) begin
      diff_sat = diff_w[31:0];
    end else begin
      diff_sat = diff_w[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    diff_ext = {diff_sat[31], diff_sat};
    upper    = {cfg_i.touch_threshold[31], cfg_i.touch_threshold}
             + $signed({2'b00, cfg_i.hysteresis_band});
    lower    = {cfg_i.touch_threshold[31], cfg_i.touch_threshold}
             - $signed({2'b00, cfg_i.hysteresis_band});
    if (touch_q) begin
      touch_d = !(diff_ext < lower);
    end else begin
      touch_d = (diff_ext > upper);
    end
    out_d.touch            = touch_d;
    out_d.force_difference = diff_sat;
    out_d.used_sample      = s1_used_q;
    out_d.spike_replaced   = s1_replaced_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q       <= '0;
      seed_q      <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      touch_q     <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= q_pop_o && !q_data_i.tare;
      out_valid_q <= s1_valid_q;
      if (q_pop_o) begin
        if (q_data_i.tare) begin
          seed_q <= 1'b1;
        end else begin
          seed_q <= 1'b0;
          avg_q  <= avg_d;
        end
      end
      if (s1_valid_q) begin
        touch_q <= touch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && q_pop_o) begin
      s1_used_q     <= q_data_i.used_sample;
      s1_replaced_q <= q_data_i.spike_replaced;
    end
    if (advance && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_tare_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_data_i.tare |=> seed_q)
    else $error("tare did not rearm seeding");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(avg_q) && $stable(touch_q))
    else $error("average or touch moved while output stalled");

endmodule

>>> hdl/load_cell_touch_detector.sv
`timescale 1ns / 1ps
// A sample beat is registered in the queue, then in stage one, then in the output register.
// Throughput: one beat per cycle unless the output stalls; the running average sets it.
// A two-entry queue parts the front from the back, so input stall rises only when it fills.
// Tare beats and samples while the probe is off give no result beat.
// Reset (async, active low) restores register defaults, clears filter state, arms seeding.
// ----------------------------------------------------------------------------
// load_cell_touch_detector - load-cell touch detector top level
// Register block on the APB-style port, front spike filter, command queue
// and back end with running average and touch hysteresis.
// ----------------------------------------------------------------------------
module load_cell_touch_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lctd_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lctd_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lctd_pkg::PADDR_W-1:0]    paddr,
  input  logic [lctd_pkg::PDATA_W-1:0]    pwdata,
  output logic [lctd_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import lctd_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_write;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_push_data, q_pop_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probe_enable    <= RST_PROBE_ENABLE;
      cfg_q.jump_limit      <= RST_JUMP_LIMIT;
      cfg_q.max_confidence  <= RST_MAX_CONFIDENCE;
      cfg_q.average_weight  <= RST_AVERAGE_WEIGHT;
      cfg_q.touch_threshold <= RST_TOUCH_THRESHOLD;
      cfg_q.hysteresis_band <= RST_HYSTERESIS_BAND;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_PROBE_ENABLE:    cfg_q.probe_enable    <= pwdata[0];
        REG_JUMP_LIMIT:      cfg_q.jump_limit      <= pwdata[30:0];
        REG_MAX_CONFIDENCE:  cfg_q.max_confidence  <= pwdata[3:0];
        REG_AVERAGE_WEIGHT:  cfg_q.average_weight  <= pwdata[16:0];
        REG_TOUCH_THRESHOLD: cfg_q.touch_threshold <= pwdata;
        REG_HYSTERESIS_BAND: cfg_q.hysteresis_band <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROBE_ENABLE:    prdata = {31'd0, cfg_q.probe_enable};
      REG_JUMP_LIMIT:      prdata = {1'b0, cfg_q.jump_limit};
      REG_MAX_CONFIDENCE:  prdata = {28'd0, cfg_q.max_confidence};
      REG_AVERAGE_WEIGHT:  prdata = {15'd0, cfg_q.average_weight};
      REG_TOUCH_THRESHOLD: prdata = cfg_q.touch_threshold;
      REG_HYSTERESIS_BAND: prdata = {1'b0, cfg_q.hysteresis_band};
      default:             prdata = '0;
    endcase
  end

  lctd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  lctd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .valid_o     (q_valid)
  );

  lctd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
